// ===== hdl/sound_unit_register_file_defines.svh =====
// ----------------------------------------------------------------------------
// Sound unit register file assertion macros
// Shared property forms for the sound unit register file checks.
// ----------------------------------------------------------------------------
`ifndef SOUND_UNIT_REGISTER_FILE_DEFINES_SVH
`define SOUND_UNIT_REGISTER_FILE_DEFINES_SVH
`ifndef SYNTH
// Implication in the same cycle, ignored while reset is held.
`define SUR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sound unit register file check failed");
// Consequence in the cycle after each cycle in which reset is held.
`define SUR_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("sound unit register file reset check failed");
`else
`define SUR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SUR_ASSERT_RESET(lbl, clk, rst_n, cons)
`endif
`endif

// ===== hdl/sur_pkg.sv =====
// ----------------------------------------------------------------------------
// Sound unit register file package
// Command types, operation codes and fixed constants of the register file.
// ----------------------------------------------------------------------------
`default_nettype none

package sur_pkg;

    // Decoded register class of one access.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LVOL,
        OP_RVOL,
        OP_PITCH,
        OP_START,
        OP_ENV1,
        OP_ENV2,
        OP_LOOP,
        OP_XADDR,
        OP_PORT,
        OP_GLOBAL,
        OP_REVERB
    } t_op;

    // One decoded access as it travels from the front to the back.
    typedef struct packed {
        logic        wr;
        t_op         op;
        logic [4:0]  idx;
        logic [15:0] wdata;
    } t_cmd;

    // Execution states of the back end.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PMUL,
        ST_DIV,
        ST_MEM,
        ST_MRD
    } t_state;

    // Global register slots inside the 0x180 window.
    localparam logic [4:0] GSlotDepthL = 5'd2;
    localparam logic [4:0] GSlotDepthR = 5'd3;
    localparam logic [4:0] GSlotIrq    = 5'd18;
    localparam logic [4:0] GSlotXaddr  = 5'd19;
    localparam logic [4:0] GSlotPort   = 5'd20;
    localparam logic [4:0] GSlotCtrl   = 5'd21;
    localparam logic [4:0] GSlotSpare  = 5'd22;
    localparam logic [4:0] GSlotStatus = 5'd23;

    // Stored global word numbers.
    localparam logic [2:0] GwDepthL = 3'd0;
    localparam logic [2:0] GwDepthR = 3'd1;
    localparam logic [2:0] GwIrq    = 3'd2;
    localparam logic [2:0] GwCtrl   = 3'd3;
    localparam logic [2:0] GwSpare  = 3'd4;
    localparam logic [2:0] GwStatus = 3'd5;
    localparam int         GwCount  = 6;

    // Voice register slots.
    localparam logic [2:0] VsLvol  = 3'd0;
    localparam logic [2:0] VsRvol  = 3'd1;
    localparam logic [2:0] VsPitch = 3'd2;
    localparam logic [2:0] VsStart = 3'd3;
    localparam logic [2:0] VsEnv1  = 3'd4;
    localparam logic [2:0] VsEnv2  = 3'd5;
    localparam logic [2:0] VsLevel = 3'd6;
    localparam logic [2:0] VsLoop  = 3'd7;

    localparam int          VoiceMax    = 24;
    localparam logic [9:0]  GlobalBase  = 10'h180;
    localparam logic [9:0]  GlobalEnd   = 10'h1b8;
    localparam logic [9:0]  ReverbBase  = 10'h1c0;
    localparam logic [9:0]  ReverbEnd   = 10'h200;
    localparam logic [15:0] StatusMask  = 16'hf800;
    localparam logic [15:0] Env2Mask    = 16'hdfff;
    localparam logic [15:0] SpareReset  = 16'h0004;
    localparam logic [13:0] PitchMax    = 14'h3fff;
    localparam logic [15:0] SampleRate  = 16'd44100;
    localparam logic [18:0] XaddrMax    = 19'h7ffff;

endpackage

`default_nettype wire

// ===== hdl/sur_front.sv =====
// ----------------------------------------------------------------------------
// Sound unit register file front end
// Decodes the byte offset of an access into a register class and index.
// ----------------------------------------------------------------------------
`default_nettype none

module sur_front #(
    parameter int VOICES       = 24,
    parameter int REVERB_WORDS = 32
) (
    input  wire logic        i_kind,
    input  wire logic [9:0]  i_offset,
    input  wire logic [15:0] i_wdata,
    output sur_pkg::t_cmd    o_cmd
);

    logic [5:0] voice;
    logic [2:0] vslot;
    logic [9:0] grel;
    logic [4:0] gslot;
    logic [4:0] ridx;

    assign voice = i_offset[9:4];
    assign vslot = i_offset[3:1];
    assign grel  = {i_offset[9:1], 1'b0} - sur_pkg::GlobalBase;
    assign gslot = grel[5:1];
    assign ridx  = i_offset[5:1];

    // Classify the access by address range, then by slot.
    always_comb begin
        o_cmd.wr    = i_kind;
        o_cmd.wdata = i_wdata;
        o_cmd.op    = sur_pkg::OP_NONE;
        o_cmd.idx   = 5'd0;
        if (voice < 6'(sur_pkg::VoiceMax)) begin
            o_cmd.idx = voice[4:0];
            if (voice < 6'(VOICES)) begin
                unique case (vslot)
                    sur_pkg::VsLvol:  o_cmd.op = sur_pkg::OP_LVOL;
                    sur_pkg::VsRvol:  o_cmd.op = sur_pkg::OP_RVOL;
                    sur_pkg::VsPitch: o_cmd.op = sur_pkg::OP_PITCH;
                    sur_pkg::VsStart: o_cmd.op = sur_pkg::OP_START;
                    sur_pkg::VsEnv1:  o_cmd.op = sur_pkg::OP_ENV1;
                    sur_pkg::VsEnv2:  o_cmd.op = sur_pkg::OP_ENV2;
                    sur_pkg::VsLevel: o_cmd.op = sur_pkg::OP_NONE;
                    sur_pkg::VsLoop:  o_cmd.op = sur_pkg::OP_LOOP;
                    default:          o_cmd.op = sur_pkg::OP_NONE;
                endcase
            end
        end else if (i_offset >= sur_pkg::GlobalBase && i_offset < sur_pkg::GlobalEnd) begin
            unique case (gslot)
                sur_pkg::GSlotXaddr: o_cmd.op = sur_pkg::OP_XADDR;
                sur_pkg::GSlotPort:  o_cmd.op = sur_pkg::OP_PORT;
                sur_pkg::GSlotDepthL: begin
                    o_cmd.op  = sur_pkg::OP_GLOBAL;
                    o_cmd.idx = {2'b00, sur_pkg::GwDepthL};
                end
                sur_pkg::GSlotDepthR: begin
                    o_cmd.op  = sur_pkg::OP_GLOBAL;
                    o_cmd.idx = {2'b00, sur_pkg::GwDepthR};
                end
                sur_pkg::GSlotIrq: begin
                    o_cmd.op  = sur_pkg::OP_GLOBAL;
                    o_cmd.idx = {2'b00, sur_pkg::GwIrq};
                end
                sur_pkg::GSlotCtrl: begin
                    o_cmd.op  = sur_pkg::OP_GLOBAL;
                    o_cmd.idx = {2'b00, sur_pkg::GwCtrl};
                end
                sur_pkg::GSlotSpare: begin
                    o_cmd.op  = sur_pkg::OP_GLOBAL;
                    o_cmd.idx = {2'b00, sur_pkg::GwSpare};
                end
                sur_pkg::GSlotStatus: begin
                    o_cmd.op  = sur_pkg::OP_GLOBAL;
                    o_cmd.idx = {2'b00, sur_pkg::GwStatus};
                end
                default: o_cmd.op = sur_pkg::OP_NONE;
            endcase
        end else if (i_offset >= sur_pkg::ReverbBase && i_offset < sur_pkg::ReverbEnd) begin
            if (6'(ridx) < 6'(REVERB_WORDS)) begin
                o_cmd.op  = sur_pkg::OP_REVERB;
                o_cmd.idx = ridx;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sur_fifo.sv =====
// ----------------------------------------------------------------------------
// Sound unit register file command queue
// Two-entry queue of decoded commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sur_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  sur_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output sur_pkg::t_cmd      o_cmd
);

    sur_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

`default_nettype wire

// ===== hdl/sur_back.sv =====
// ----------------------------------------------------------------------------
// Sound unit register file back end
// Holds the register state and sound memory and executes queued commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sur_back #(
    parameter int VOICES       = 24,
    parameter int MEM_WORDS    = 262144,
    parameter int REVERB_WORDS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  sur_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  wire logic          i_out_pop,
    output logic               o_out_valid,
    output logic [15:0]        o_rdata,
    output logic               o_busy
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int RW = (REVERB_WORDS > 1) ? $clog2(REVERB_WORDS) : 1;
    localparam int MW = $clog2(MEM_WORDS);
    // The rate read is f * 4096 / 44100 = f * 1024 / 11025. A rounded-up
    // reciprocal of 11025 scaled by 2^42 is exact for every rate that a
    // 14-bit pitch can give, and the factor 1024 folds into a 32-bit shift.
    localparam logic [63:0] RateQuarter = 64'(sur_pkg::SampleRate) >> 2;
    localparam logic [28:0] PitchRecip  =
        29'(((64'd1 << 42) + RateQuarter - 64'd1) / RateQuarter);
    // Rounded-up reciprocal of MEM_WORDS scaled by 2^36; exact for any
    // 18-bit word address.
    localparam logic [26:0] MemRecip =
        27'(((64'd1 << 36) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));

    // Volume write encoding, sweep or fixed, to stored level.
    function automatic logic [15:0] vol_level(input logic [15:0] w);
        logic [15:0] x;
        logic [7:0]  m;
        logic [7:0]  s;
        x = w[12] ? ~w : w;
        m = ({1'b0, x[6:0]} + 8'd1) >> 1;
        s = w[13] ? (m - (m >> 1)) : (m + (m >> 1));
        if (w[15]) begin
            return {1'b0, s, 7'b0};
        end else if (w[14]) begin
            return {2'b00, sur_pkg::PitchMax - w[13:0]};
        end else begin
            return w;
        end
    endfunction

    // Flags: bit 0 sweep, bit 1 exponential, bit 2 decreasing.
    function automatic logic [2:0] vol_flags(input logic [15:0] w, input logic [2:0] f);
        return w[15] ? {w[13], w[14], 1'b1} : {f[2:1], 1'b0};
    endfunction

    function automatic logic [15:0] vol_read(input logic [15:0] lv, input logic [2:0] f);
        return f[0] ? {1'b1, f[1], f[2], 6'b0, lv[6:0]} : {1'b0, lv[14:0]};
    endfunction

    logic [15:0] r_lvl_l [VOICES];
    logic [15:0] r_lvl_r [VOICES];
    logic [2:0]  r_flg_l [VOICES];
    logic [2:0]  r_flg_r [VOICES];
    logic [13:0] r_pitch [VOICES];
    logic [15:0] r_env1  [VOICES];
    logic [15:0] r_env2  [VOICES];
    logic [15:0] r_start [VOICES];
    logic [15:0] r_loop  [VOICES];
    logic [15:0] r_glob  [sur_pkg::GwCount];
    logic [15:0] r_rvb   [REVERB_WORDS];
    logic [15:0] mem     [MEM_WORDS];

    sur_pkg::t_state r_state, n_state;
    sur_pkg::t_cmd   r_cmd,   n_cmd;
    logic [29:0]     r_prod,  n_prod;
    logic [47:0]     r_scl,   n_scl;
    logic            r_div_pitch, n_div_pitch;
    logic [MW-1:0]   r_midx,  n_midx;
    logic [18:0]     r_addr,  n_addr;
    logic            r_out_valid, n_out_valid;
    logic [15:0]     r_out_data,  n_out_data;
    logic [15:0]     r_mem_rd;

    logic            take;
    logic            wr_take;
    logic [VW-1:0]   vi;
    logic [RW-1:0]   ri;
    logic [17:0]     word_idx;
    logic [17:0]     f_raw;
    logic [17:0]     f_rate;
    logic [19:0]     addr_sum;
    logic [7:0]      mem_quo;
    logic [26:0]     mem_back;
    logic [26:0]     mem_red;
    logic [15:0]     rd_val;
    logic            mem_en;

    assign vi       = i_cmd.idx[VW-1:0];
    assign ri       = i_cmd.idx[RW-1:0];
    assign word_idx = r_addr[18:1];
    assign f_raw    = r_prod[29:12];
    // The rate never reads as zero.
    assign f_rate   = (f_raw == 18'd0) ? 18'd1 : f_raw;
    assign addr_sum = {1'b0, r_addr} + 20'd2;
    assign mem_quo  = r_scl[43:36];
    assign mem_back = 27'(mem_quo) * 27'(MEM_WORDS);
    assign mem_red  = {9'd0, word_idx} - mem_back;
    assign mem_en   = (r_state == sur_pkg::ST_MEM);

    // A read is only started once the result register is free.
    assign take      = (r_state == sur_pkg::ST_IDLE) && i_cmd_valid &&
                       (i_cmd.wr || !r_out_valid);
    assign wr_take   = take && i_cmd.wr;
    assign o_cmd_pop = take;
    assign o_busy    = (r_state != sur_pkg::ST_IDLE);

    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_out_data;

    // Read data of the registers served from the idle state.
    always_comb begin
        rd_val = 16'd0;
        unique case (i_cmd.op)
            sur_pkg::OP_LVOL:   rd_val = vol_read(r_lvl_l[vi], r_flg_l[vi]);
            sur_pkg::OP_RVOL:   rd_val = vol_read(r_lvl_r[vi], r_flg_r[vi]);
            sur_pkg::OP_START:  rd_val = r_start[vi];
            sur_pkg::OP_ENV1:   rd_val = r_env1[vi];
            sur_pkg::OP_ENV2:   rd_val = r_env2[vi] & sur_pkg::Env2Mask;
            sur_pkg::OP_LOOP:   rd_val = r_loop[vi];
            sur_pkg::OP_XADDR:  rd_val = r_addr[18:3];
            sur_pkg::OP_GLOBAL: rd_val = r_glob[i_cmd.idx[2:0]];
            sur_pkg::OP_REVERB: rd_val = r_rvb[ri];
            default:            rd_val = 16'd0;
        endcase
    end

    // Next state, read data and the pitch and data port steps.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_prod      = r_prod;
        n_scl       = r_scl;
        n_div_pitch = r_div_pitch;
        n_midx      = r_midx;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && !i_out_pop;
        n_out_data  = r_out_data;
        unique case (r_state)
            sur_pkg::ST_IDLE: begin
                if (take) begin
                    n_cmd = i_cmd;
                    // A write leaves a waiting result untouched.
                    if (!i_cmd.wr) begin
                        n_out_valid = 1'b1;
                        n_out_data  = rd_val;
                    end
                    unique case (i_cmd.op)
                        sur_pkg::OP_PITCH: begin
                            if (!i_cmd.wr) begin
                                n_out_valid = 1'b0;
                                n_prod  = 30'(r_pitch[vi]) * 30'(sur_pkg::SampleRate);
                                n_state = sur_pkg::ST_PMUL;
                            end
                        end
                        sur_pkg::OP_XADDR: begin
                            if (i_cmd.wr) n_addr = {i_cmd.wdata, 3'b000};
                        end
                        sur_pkg::OP_PORT: begin
                            if (!i_cmd.wr) n_out_valid = 1'b0;
                            if ({1'b0, word_idx} < 19'(MEM_WORDS)) begin
                                n_midx  = word_idx[MW-1:0];
                                n_state = sur_pkg::ST_MEM;
                            end else begin
                                n_scl       = 48'(word_idx) * 48'(MemRecip);
                                n_div_pitch = 1'b0;
                                n_state     = sur_pkg::ST_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sur_pkg::ST_PMUL: begin
                // Reciprocal multiply in place of the division by the rate.
                n_scl       = 48'(f_rate) * 48'(PitchRecip);
                n_div_pitch = 1'b1;
                n_state     = sur_pkg::ST_DIV;
            end
            sur_pkg::ST_DIV: begin
                // Take the quotient, or reduce the word address by it.
                if (r_div_pitch) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, r_scl[45:32]};
                    n_state     = sur_pkg::ST_IDLE;
                end else begin
                    n_midx  = mem_red[MW-1:0];
                    n_state = sur_pkg::ST_MEM;
                end
            end
            sur_pkg::ST_MEM: begin
                n_addr  = (addr_sum > {1'b0, sur_pkg::XaddrMax}) ? 19'd0 : addr_sum[18:0];
                n_state = r_cmd.wr ? sur_pkg::ST_IDLE : sur_pkg::ST_MRD;
            end
            sur_pkg::ST_MRD: begin
                n_out_valid = 1'b1;
                n_out_data  = r_mem_rd;
                n_state     = sur_pkg::ST_IDLE;
            end
            default: n_state = sur_pkg::ST_IDLE;
        endcase
    end

    // Control and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sur_pkg::ST_IDLE;
            r_addr      <= 19'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
        r_cmd       <= n_cmd;
        r_prod      <= n_prod;
        r_scl       <= n_scl;
        r_div_pitch <= n_div_pitch;
        r_midx      <= n_midx;
        r_out_data  <= n_out_data;
    end

    // Voice, global and reverb register state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VOICES; k++) begin
                r_lvl_l[k] <= 16'd0;
                r_lvl_r[k] <= 16'd0;
                r_flg_l[k] <= 3'd0;
                r_flg_r[k] <= 3'd0;
                r_pitch[k] <= 14'd0;
                r_env1[k]  <= 16'd0;
                r_env2[k]  <= 16'd0;
                r_start[k] <= 16'd0;
                r_loop[k]  <= 16'd0;
            end
            for (int k = 0; k < sur_pkg::GwCount; k++) begin
                r_glob[k] <= 16'd0;
            end
            r_glob[sur_pkg::GwSpare] <= sur_pkg::SpareReset;
            for (int k = 0; k < REVERB_WORDS; k++) begin
                r_rvb[k] <= 16'd0;
            end
        end else if (wr_take) begin
            unique case (i_cmd.op)
                sur_pkg::OP_LVOL: begin
                    r_lvl_l[vi] <= vol_level(i_cmd.wdata);
                    r_flg_l[vi] <= vol_flags(i_cmd.wdata, r_flg_l[vi]);
                end
                sur_pkg::OP_RVOL: begin
                    r_lvl_r[vi] <= vol_level(i_cmd.wdata);
                    r_flg_r[vi] <= vol_flags(i_cmd.wdata, r_flg_r[vi]);
                end
                sur_pkg::OP_PITCH: begin
                    r_pitch[vi] <= (i_cmd.wdata > 16'(sur_pkg::PitchMax)) ?
                                   sur_pkg::PitchMax : i_cmd.wdata[13:0];
                end
                sur_pkg::OP_START: r_start[vi] <= i_cmd.wdata;
                sur_pkg::OP_ENV1:  r_env1[vi]  <= i_cmd.wdata;
                sur_pkg::OP_ENV2:  r_env2[vi]  <= i_cmd.wdata;
                sur_pkg::OP_LOOP:  r_loop[vi]  <= i_cmd.wdata;
                sur_pkg::OP_GLOBAL: begin
                    r_glob[i_cmd.idx[2:0]] <= (i_cmd.idx[2:0] == sur_pkg::GwStatus) ?
                        (i_cmd.wdata & sur_pkg::StatusMask) : i_cmd.wdata;
                end
                sur_pkg::OP_REVERB: r_rvb[ri] <= i_cmd.wdata;
                default: ;
            endcase
        end
    end

    // Sound memory: one port, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_en) begin
            if (r_cmd.wr) mem[r_midx] <= r_cmd.wdata;
            else          r_mem_rd <= mem[r_midx];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sound_unit_register_file.sv =====
// ----------------------------------------------------------------------------
// Sound unit register file
// Sixteen-bit register window with voice registers, globals and sound memory.
// ----------------------------------------------------------------------------
// Accesses enter through a two-entry command queue and are executed one at a
// time; an accepted access waits in the queue until the back end takes it.
// Most registers are served from the idle state. A sound-memory data port
// write passes through the address and memory steps, a read also through read
// data, with a step that reduces the word address when it lies beyond
// MEM_WORDS. A pitch read passes through the rate product, a reciprocal
// multiply in place of the division by the sample rate, and the result. A read
// result waits in the output register, and the next read starts only once it
// is transferred. Reads deliver one result each; writes none.
`default_nettype none
`include "sound_unit_register_file_defines.svh"

module sound_unit_register_file #(
    parameter int VOICES       = 24,
    parameter int MEM_WORDS    = 262144,
    parameter int REVERB_WORDS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_kind,
    input  wire logic [9:0]  i_offset,
    input  wire logic [15:0] i_wdata,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_rdata
);

    sur_pkg::t_cmd dec_cmd;
    sur_pkg::t_cmd q_cmd;
    logic          q_valid;
    logic          q_pop;
    logic          out_valid;
    logic          busy;

    // Offset decode.
    sur_front #(
        .VOICES       (VOICES),
        .REVERB_WORDS (REVERB_WORDS)
    ) u_front (
        .i_kind   (i_kind),
        .i_offset (i_offset),
        .i_wdata  (i_wdata),
        .o_cmd    (dec_cmd)
    );

    // Command queue between decode and execution.
    sur_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (dec_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Execution and storage.
    sur_back #(
        .VOICES       (VOICES),
        .MEM_WORDS    (MEM_WORDS),
        .REVERB_WORDS (REVERB_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_out_pop   (pop),
        .o_out_valid (out_valid),
        .o_rdata     (o_rdata),
        .o_busy      (busy)
    );

    assign empty = !out_valid;

    // Checks.
    `SUR_ASSERT_RESET(a_reset_empty, i_clk, i_rst_n, empty)
    `SUR_ASSERT_IMPL(a_pop_when_idle, i_clk, i_rst_n, q_pop, !busy && q_valid)
    `SUR_ASSERT_IMPL(a_full_has_cmd, i_clk, i_rst_n, full, q_valid)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Sound unit register file testbench
// Drives read and write transfers through the queue-style input and checks
// every read result against a predictor that mirrors the register behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KindRead  = 1'b0;
    localparam logic KindWrite = 1'b1;

    typedef struct {
        logic        kind;
        logic [9:0]  offset;
        logic [15:0] wdata;
    } t_access;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_kind = 1'b0;
    logic [9:0]  i_offset = '0;
    logic [15:0] i_wdata = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_rdata;

    sound_unit_register_file u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_kind   (i_kind),
        .i_offset (i_offset),
        .i_wdata  (i_wdata),
        .empty    (empty),
        .pop      (pop),
        .o_rdata  (o_rdata)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicted register state.
    logic [15:0] lvl_left  [sur_pkg::VoiceMax];
    logic [15:0] lvl_right [sur_pkg::VoiceMax];
    logic [5:0]  sweep     [sur_pkg::VoiceMax];
    logic [13:0] pitch_raw [sur_pkg::VoiceMax];
    logic [15:0] env_one   [sur_pkg::VoiceMax];
    logic [15:0] env_two   [sur_pkg::VoiceMax];
    logic [31:0] addr_words[sur_pkg::VoiceMax];
    logic [15:0] gwords    [sur_pkg::GwCount];
    logic [15:0] reverb    [32];
    logic [15:0] smem      [int];
    logic [18:0] xaddr;

    t_access     pending_accesses[$];
    logic [15:0] expected_reads[$];
    int          fails = 0;
    int          n_reads = 0;
    int          n_writes = 0;
    int          n_checked = 0;
    int          n_sent = 0;
    logic        rx_hold = 1'b0;

    // One line per mismatch, and a count.
    task automatic report(input string what);
        fails++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // Volume write: sweep encoding or fixed level.
    task automatic write_volume(input bit right, input int v, input logic [15:0] w);
        logic [15:0] x;
        int unsigned m;
        logic [2:0] f;
        logic [15:0] lv;
        int sh;
        sh = right ? 3 : 0;
        if (w[15]) begin
            x = w[12] ? ~w : w;
            m = ({25'd0, x[6:0]} + 1) / 2;
            m = w[13] ? m - m / 2 : m + m / 2;
            lv = 16'(m * 128);
            f = {w[13], w[14], 1'b1};
            sweep[v] = (sweep[v] & ~(6'd7 << sh)) | (6'(f) << sh);
        end else begin
            lv = w[14] ? 16'(16'h3fff - {2'b0, w[13:0]}) : w;
            sweep[v][sh] = 1'b0;
        end
        if (right) lvl_right[v] = lv;
        else lvl_left[v] = lv;
    endtask

    function automatic logic [15:0] read_volume(input bit right, input int v);
        logic [2:0] f;
        logic [15:0] lv;
        f = right ? sweep[v][5:3] : sweep[v][2:0];
        lv = right ? lvl_right[v] : lvl_left[v];
        if (f[0]) return {1'b1, f[1], f[2], 6'd0, lv[6:0]};
        return {1'b0, lv[14:0]};
    endfunction

    function automatic int global_word(input logic [4:0] slot);
        case (slot)
            sur_pkg::GSlotDepthL: return sur_pkg::GwDepthL;
            sur_pkg::GSlotDepthR: return sur_pkg::GwDepthR;
            sur_pkg::GSlotIrq:    return sur_pkg::GwIrq;
            sur_pkg::GSlotCtrl:   return sur_pkg::GwCtrl;
            sur_pkg::GSlotSpare:  return sur_pkg::GwSpare;
            sur_pkg::GSlotStatus: return sur_pkg::GwStatus;
            default:              return -1;
        endcase
    endfunction

    // Applies one access to the predicted state; returns whether a read result follows.
    task automatic apply_access(input t_access a, output bit has_rd, output logic [15:0] r);
        logic [9:0] off;
        int v, g, idx;
        logic [4:0] gs;
        int unsigned f;
        off = {a.offset[9:1], 1'b0};
        v = off >> 4;
        r = '0;
        has_rd = (a.kind == KindRead);
        if (v < sur_pkg::VoiceMax) begin
            case (off[3:1])
                sur_pkg::VsLvol:
                    if (a.kind) write_volume(0, v, a.wdata); else r = read_volume(0, v);
                sur_pkg::VsRvol:
                    if (a.kind) write_volume(1, v, a.wdata); else r = read_volume(1, v);
                sur_pkg::VsPitch: begin
                    if (a.kind) begin
                        pitch_raw[v] = (a.wdata > 16'h3fff) ? sur_pkg::PitchMax
                                                            : a.wdata[13:0];
                    end else begin
                        f = 44100 * pitch_raw[v] / 4096;
                        if (f < 1) f = 1;
                        r = 16'(f * 4096 / 44100);
                    end
                end
                sur_pkg::VsStart:
                    if (a.kind) addr_words[v][15:0] = a.wdata; else r = addr_words[v][15:0];
                sur_pkg::VsEnv1: if (a.kind) env_one[v] = a.wdata; else r = env_one[v];
                sur_pkg::VsEnv2:
                    if (a.kind) env_two[v] = a.wdata; else r = env_two[v] & sur_pkg::Env2Mask;
                sur_pkg::VsLoop:
                    if (a.kind) addr_words[v][31:16] = a.wdata; else r = addr_words[v][31:16];
                default: ;
            endcase
        end else if (off >= sur_pkg::GlobalBase && off < sur_pkg::GlobalEnd) begin
            gs = 5'((off - sur_pkg::GlobalBase) >> 1);
            if (gs == sur_pkg::GSlotXaddr) begin
                if (a.kind) xaddr = {a.wdata, 3'b0};
                else r = 16'(xaddr >> 3);
            end else if (gs == sur_pkg::GSlotPort) begin
                idx = int'(xaddr >> 1);
                if (a.kind) smem[idx] = a.wdata;
                else r = smem[idx];
                xaddr = (xaddr == sur_pkg::XaddrMax - 1) ? '0 : xaddr + 19'd2;
            end else begin
                g = global_word(gs);
                if (g >= 0) begin
                    if (a.kind)
                        gwords[g] = (g == sur_pkg::GwStatus) ?
                                    (a.wdata & sur_pkg::StatusMask) : a.wdata;
                    else r = gwords[g];
                end
            end
        end else if (off >= sur_pkg::ReverbBase && off < sur_pkg::ReverbEnd) begin
            idx = (off - sur_pkg::ReverbBase) >> 1;
            if (a.kind) reverb[idx] = a.wdata; else r = reverb[idx];
        end
    endtask

    // Queues one access; a data port read of a never-written word becomes a write.
    task automatic add_access(input logic k, input logic [9:0] o, input logic [15:0] w);
        t_access a;
        bit has_rd;
        logic [15:0] r;
        a.kind = k;
        a.offset = o;
        a.wdata = w;
        if (k == KindRead && o[9:1] == 9'((sur_pkg::GlobalBase >> 1) + sur_pkg::GSlotPort)
            && !smem.exists(int'(xaddr >> 1)))
            a.kind = KindWrite;
        apply_access(a, has_rd, r);
        if (has_rd) begin
            expected_reads.push_back(r);
            n_reads++;
        end else begin
            n_writes++;
        end
        pending_accesses.push_back(a);
    endtask

    function automatic logic [9:0] voice_off(input int v, input logic [2:0] slot);
        return 10'(v * 16) | {6'd0, slot, 1'b0};
    endfunction

    function automatic logic [9:0] global_off(input logic [4:0] slot);
        return sur_pkg::GlobalBase + {4'd0, slot, 1'b0};
    endfunction

    // Directed accesses, then random well-formed traffic.
    task automatic build_stimulus();
        int v, n, k;
        logic [15:0] base;
        // Volume encodings, pitch clamp and envelope masking.
        add_access(KindWrite, voice_off(0, sur_pkg::VsLvol), 16'hf07f);
        add_access(KindWrite, voice_off(0, sur_pkg::VsRvol), 16'ha000);
        add_access(KindRead,  voice_off(0, sur_pkg::VsLvol), '0);
        add_access(KindRead,  voice_off(0, sur_pkg::VsRvol), '0);
        add_access(KindWrite, voice_off(0, sur_pkg::VsLvol), 16'h7fff);
        add_access(KindRead,  voice_off(0, sur_pkg::VsLvol), '0);
        add_access(KindWrite, voice_off(23, sur_pkg::VsPitch), 16'hffff);
        add_access(KindRead,  voice_off(23, sur_pkg::VsPitch), '0);
        add_access(KindRead,  voice_off(1, sur_pkg::VsPitch), '0);
        add_access(KindWrite, voice_off(23, sur_pkg::VsEnv2), 16'hffff);
        add_access(KindRead,  voice_off(23, sur_pkg::VsEnv2), '0);
        add_access(KindWrite, voice_off(23, sur_pkg::VsLevel), 16'h1234);
        add_access(KindRead,  voice_off(23, sur_pkg::VsLevel), '0);
        // Status mask, spare reset value and left-out globals.
        add_access(KindRead,  global_off(sur_pkg::GSlotSpare), '0);
        add_access(KindWrite, global_off(sur_pkg::GSlotStatus), 16'hffff);
        add_access(KindRead,  global_off(sur_pkg::GSlotStatus), '0);
        add_access(KindWrite, global_off(5'd4), 16'hffff);
        add_access(KindRead,  global_off(5'd4), '0);
        // Data port wrapping past the top of the address space.
        add_access(KindWrite, global_off(sur_pkg::GSlotXaddr), 16'hffff);
        for (int i = 0; i < 6; i++)
            add_access(KindWrite, global_off(sur_pkg::GSlotPort), 16'(16'hbe00 + i));
        add_access(KindRead,  global_off(sur_pkg::GSlotXaddr), '0);
        // Unmapped space and the last reverb word.
        add_access(KindWrite, 10'h3ff, 16'hffff);
        add_access(KindRead,  10'h1b9, '0);
        add_access(KindWrite, 10'h1fe, 16'h8001);
        add_access(KindRead,  10'h1fe, '0);
        // Random part.
        while (pending_accesses.size() < 975) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                v = $urandom_range(0, sur_pkg::VoiceMax - 1);
                add_access(1'($urandom), voice_off(v, 3'($urandom)) | 10'($urandom_range(0, 1)),
                           16'($urandom));
            end else if (k < 60) begin
                add_access(1'($urandom), sur_pkg::GlobalBase + 10'($urandom_range(0, 55)),
                           16'($urandom));
            end else if (k < 72) begin
                // Burst of port writes, then read back from the same address.
                base = ($urandom_range(0, 7) == 0) ? 16'hfffe : 16'($urandom);
                n = $urandom_range(1, 6);
                add_access(KindWrite, global_off(sur_pkg::GSlotXaddr), base);
                for (int i = 0; i < n; i++)
                    add_access(KindWrite, global_off(sur_pkg::GSlotPort), 16'($urandom));
                add_access(KindWrite, global_off(sur_pkg::GSlotXaddr), base);
                for (int i = 0; i < n; i++)
                    add_access(KindRead, global_off(sur_pkg::GSlotPort), 16'($urandom));
            end else if (k < 88) begin
                add_access(1'($urandom), sur_pkg::ReverbBase + 10'($urandom_range(0, 63)),
                           16'($urandom));
            end else begin
                add_access(1'($urandom), 10'($urandom_range(10'h1b8, 10'h3ff)), 16'($urandom));
            end
        end
    endtask

    // Sender: bursts of transfers separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                void'(pending_accesses.pop_front());
                n_sent++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                push <= 1'b1;
                i_kind <= pending_accesses[0].kind;
                i_offset <= pending_accesses[0].offset;
                i_wdata <= pending_accesses[0].wdata;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: stalls on its own pattern, with stall-free stretches and one long hold.
    int rx_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_reads.size() == 0) begin
                    report($sformatf("read data 0x%04h with no read outstanding", o_rdata));
                end else begin
                    if (o_rdata !== expected_reads[0])
                        report($sformatf("rdata 0x%04h, expected 0x%04h",
                                         o_rdata, expected_reads[0]));
                    void'(expected_reads.pop_front());
                    n_checked++;
                end
            end
            rx_phase = (rx_phase + 1) % 160;
            if (rx_hold) pop <= 1'b0;
            else if (rx_phase < 60) pop <= 1'b1;
            else pop <= ($urandom_range(0, 2) != 0);
        end
    end

    // Long receiver hold-off while the sender keeps offering transfers.
    initial begin
        wait (n_sent >= 300);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Run limit.
    initial begin
        #3ms;
        $display("Timeout at %0t", $time);
        $display("** sound_unit_register_file: FAILED **");
        $finish;
    end

    // Reset, stimulus and end of run.
    initial begin
        for (int v = 0; v < sur_pkg::VoiceMax; v++) begin
            lvl_left[v] = '0; lvl_right[v] = '0; sweep[v] = '0; pitch_raw[v] = '0;
            env_one[v] = '0; env_two[v] = '0; addr_words[v] = '0;
        end
        for (int g = 0; g < sur_pkg::GwCount; g++) gwords[g] = '0;
        gwords[sur_pkg::GwSpare] = sur_pkg::SpareReset;
        for (int i = 0; i < 32; i++) reverb[i] = '0;
        xaddr = '0;
        build_stimulus();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_accesses.size() == 0);
        wait (expected_reads.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("Covered %0d transfers: %0d reads checked, %0d writes.",
                 n_sent, n_checked, n_writes);
        if (fails == 0) begin
            $display("** sound_unit_register_file: PASSED **");
        end else begin
            $display("%0d mismatches", fails);
            $display("** sound_unit_register_file: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
